### hw/rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg: shared types and constants of the bucket sort engine
// Key widths, configuration register indexes, sequencer states and the
// response word of the bucket width divider.
// ----------------------------------------------------------------------------
package bse_pkg;

    // Key range, counts and register data are 7 bits wide (0..127).
    localparam int KEY_W = 7;
    // Bucket index field width.
    localparam int BKT_W = 6;
    // Configuration register index width.
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_VALUE_BITS = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_N_ITEMS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_N_BUCKETS = 2'd1;

    // Register values after reset.
    localparam logic [KEY_W-1:0] RST_N_ITEMS   = 7'd64;
    localparam logic [KEY_W-1:0] RST_N_BUCKETS = 7'd8;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_CNT_RD   = 6'b000010,
        S_CNT_CMP  = 6'b000100,
        S_DIV      = 6'b001000,
        S_SCAN_RD  = 6'b010000,
        S_SCAN_CMP = 6'b100000
    } seq_state_t;

    // Divider response: done pulse and the quotient that goes with it.
    typedef struct packed {
        logic             done;
        logic [KEY_W-1:0] quot;
    } div_rsp_t;

endpackage

### hw/rtl/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/bse_div.sv
// ----------------------------------------------------------------------------
// bse_div: iterative restoring divider for bucket widths
// One quotient bit per cycle while busy; done is high for a single cycle, together with the final quotient.
// ----------------------------------------------------------------------------
module bse_div
    (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bse_pkg::KEY_W-1:0] numer,
    input  logic [bse_pkg::KEY_W-1:0] denom,
    output bse_pkg::div_rsp_t         rsp
);
    import bse_pkg::*;

    localparam int STEP_W = $clog2(KEY_W);

    logic [KEY_W-1:0]  q_reg, q_next;
    logic [KEY_W:0]    rem_reg, rem_next;
    logic [KEY_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [KEY_W:0] rem_sh;
    logic           ge;

    always_comb begin
        rem_sh   = {rem_reg[KEY_W-1:0], q_reg[KEY_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        q_next   = {q_reg[KEY_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(KEY_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

### hw/rtl/bucket_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// bucket_sort_engine_unit: bucket sort engine, top level
// Loads a data set, splits the key range into buckets and streams the kept
// values out in ascending order with their bucket index.
// ----------------------------------------------------------------------------
// Usage: each input word stores one value (words are taken while s_ready
// is high); the word with s_last_in set starts the sort and s_ready stays low
// until the sort ends. The sort is a sequencer around one RAM read port and
// the compare logic on its read data: a count pass reads the L stored values,
// then every key from 0 up to the largest kept value takes a scan of the
// store, and each bucket reached adds a width division; the result side can
// stall the scan on m_ready. Values at or above the clamped n_items are
// dropped; if none is kept, nothing is sent. The final result word carries
// m_last_out. Configuration words are taken at any time but must only be
// written while the engine is idle.
// ----------------------------------------------------------------------------
module bucket_sort_engine_unit #(
    parameter int MAX_ITEMS  = bse_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = bse_pkg::DEF_VALUE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bse_pkg::KEY_W-1:0]     cfg_data,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [VALUE_BITS-1:0]         s_value,
    input  logic                          s_last_in,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [VALUE_BITS-1:0]         m_sorted_value,
    output logic [bse_pkg::BKT_W-1:0]     m_bucket_index,
    output logic                          m_last_out
);
    import bse_pkg::*;

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W = (VALUE_BITS > KEY_W) ? VALUE_BITS : KEY_W;

    // configuration registers
    logic [KEY_W-1:0] n_items_reg;
    logic [KEY_W-1:0] n_buckets_reg;

    // sequencer
    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [KEY_W-1:0] total_reg, total_next;
    logic [KEY_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [KEY_W-1:0] v_reg, v_next;
    logic [BKT_W-1:0] b_reg, b_next;
    logic [KEY_W-1:0] start_reg, start_next;
    logic [KEY_W-1:0] end_reg, end_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0] m_value_reg;
    logic [BKT_W-1:0]      m_bucket_reg;
    logic                  m_last_reg;

    // datapath
    logic [KEY_W-1:0]      n_eff, nb_eff;
    logic [VALUE_BITS-1:0] rd_data;
    logic                  wr_en;
    logic                  in_acc;
    logic                  kept, match, slot_free, emit, last_emit, last_k;
    logic                  div_start;
    logic [KEY_W-1:0]      div_span, div_left, div_numer;
    div_rsp_t              div_rsp;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign wr_en     = in_acc && (load_count_reg < CNT_W'(MAX_ITEMS));

    // Clamp the registers: n_items to 1..MAX_ITEMS, n_buckets to 1..n_items.
    always_comb begin
        n_eff = n_items_reg;
        if (n_items_reg == '0) begin
            n_eff = KEY_W'(1);
        end else if (n_items_reg > KEY_W'(MAX_ITEMS)) begin
            n_eff = KEY_W'(MAX_ITEMS);
        end
        nb_eff = n_buckets_reg;
        if (n_buckets_reg == '0) begin
            nb_eff = KEY_W'(1);
        end else if (n_buckets_reg > n_eff) begin
            nb_eff = n_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_items_reg   <= RST_N_ITEMS;
            n_buckets_reg <= RST_N_BUCKETS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_N_ITEMS:   n_items_reg   <= cfg_data;
                REG_N_BUCKETS: n_buckets_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Value store: written at the fill count while loading, read at the scan
    // index during the sort. The read address holds in the compare states,
    // so the registered read data stays valid across output stalls.
    bse_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (load_count_reg[AW-1:0]),
        .wr_data (s_value),
        .rd_addr (k_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Compare logic on the store read data: "below key range" in the count pass,
    // "equal to current key" in the emit passes.
    assign kept      = CMP_W'(rd_data) < CMP_W'(n_eff);
    assign match     = CMP_W'(rd_data) == CMP_W'(v_reg);
    assign slot_free = !m_valid_reg || m_ready;
    assign emit      = (state_reg == S_SCAN_CMP) && match && slot_free;
    assign last_emit = emit && ((emit_cnt_reg + 1'b1) == total_reg);
    assign last_k    = (k_reg == (load_count_reg - 1'b1));

    // Bucket width = ceil(span / left) = (span + left - 1) / left.
    always_comb begin
        if (state_reg == S_CNT_CMP) begin
            div_span = n_eff;
            div_left = nb_eff;
        end else begin
            div_span = n_eff - end_reg;
            div_left = nb_eff - KEY_W'(b_reg) - 1'b1;
        end
        div_numer = div_span + div_left - 1'b1;
    end

    bse_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_left),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        k_next          = k_reg;
        total_next      = total_reg;
        emit_cnt_next   = emit_cnt_reg;
        v_next          = v_reg;
        b_next          = b_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (wr_en) begin
                        load_count_next = load_count_reg + 1'b1;
                    end
                    if (s_last_in) begin
                        k_next     = '0;
                        total_next = '0;
                        state_next = S_CNT_RD;
                    end
                end
            end
            S_CNT_RD: begin
                state_next = S_CNT_CMP;
            end
            S_CNT_CMP: begin
                total_next = total_reg + KEY_W'(kept);
                if (!last_k) begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_CNT_RD;
                end else if (total_next == '0) begin
                    // nothing kept: drop the data set
                    load_count_next = '0;
                    state_next      = S_IDLE;
                end else begin
                    emit_cnt_next = '0;
                    v_next        = '0;
                    b_next        = '0;
                    start_next    = '0;
                    div_start     = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    end_next   = start_reg + div_rsp.quot;
                    k_next     = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (!(match && !slot_free)) begin
                    if (emit) begin
                        emit_cnt_next = emit_cnt_reg + 1'b1;
                    end
                    if (last_emit) begin
                        load_count_next = '0;
                        state_next      = S_IDLE;
                    end else if (!last_k) begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end else begin
                        v_next = v_reg + 1'b1;
                        k_next = '0;
                        if (v_next == end_reg) begin
                            // advance to the next bucket
                            b_next     = b_reg + 1'b1;
                            start_next = end_reg;
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end else begin
                            state_next = S_SCAN_RD;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            load_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        total_reg    <= total_next;
        emit_cnt_reg <= emit_cnt_next;
        v_reg        <= v_next;
        b_reg        <= b_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
    end

    // Result register: load on emit, drop valid once taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_value_reg  <= rd_data;
            m_bucket_reg <= b_reg;
            m_last_reg   <= last_emit;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_bucket_index = m_bucket_reg;
    assign m_last_out     = m_last_reg;

`ifndef SYNTHESIS
    a_emit_in_bucket: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (v_reg >= start_reg && v_reg < end_reg))
        else $error("emitted key outside its bucket range");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN_CMP) |-> (emit_cnt_reg < total_reg))
        else $error("emit count reached kept total while scanning");

    a_width_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_rsp.done) |-> (div_rsp.quot != '0))
        else $error("zero bucket width");

    a_load_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        load_count_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count above store depth");

    a_load_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |=>
            (load_count_reg == $past(load_count_reg) || load_count_reg == '0))
        else $error("fill count changed during sort");
`endif

endmodule

### sim/bse_sort_checker.sv
// ----------------------------------------------------------------------------
// bse_sort_checker: result predictor and scoreboard of the bucket sort engine
// Watches the configuration, input and result channels, rebuilds each data
// set, predicts the sorted words of every sort and compares them in order.
// ----------------------------------------------------------------------------
module bse_sort_checker #(
    parameter int MAX_ITEMS  = bse_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = bse_pkg::DEF_VALUE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bse_pkg::KEY_W-1:0]     cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [VALUE_BITS-1:0]         s_value,
    input  logic                          s_last_in,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [VALUE_BITS-1:0]         m_sorted_value,
    input  logic [bse_pkg::BKT_W-1:0]     m_bucket_index,
    input  logic                          m_last_out,
    output int                            fail_count,
    output int                            pending,
    output int                            checked
);
    import bse_pkg::*;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [BKT_W-1:0]      bucket;
        logic                  last;
    } sorted_word_t;

    sorted_word_t          sorted_q[$];
    logic [VALUE_BITS-1:0] value_mem [MAX_ITEMS];
    logic [KEY_W-1:0]      items_reg;
    logic [KEY_W-1:0]      buckets_reg;
    int                    loaded;
    int                    errs;
    int                    seen;

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        errs       = 0;
        seen       = 0;
        loaded     = 0;
    end

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s is %0d, predicted %0d", $time, what, got, want);
        errs++;
    endtask

    // Walk the keys of each bucket in ascending order; duplicates keep
    // arrival order, which equals a stable in-bucket sort.
    task automatic sort_loaded();
        int           n;
        int           nb;
        int           lo;
        int           width;
        int           b;
        int           key;
        int           k;
        int           first;
        sorted_word_t w;
        n = int'(items_reg);
        if (n < 1) n = 1;
        if (n > MAX_ITEMS) n = MAX_ITEMS;
        nb = int'(buckets_reg);
        if (nb < 1) nb = 1;
        if (nb > n) nb = n;
        first = sorted_q.size();
        lo = 0;
        for (b = 0; b < nb; b++) begin
            width = (n - lo + (nb - b) - 1) / (nb - b);
            for (key = lo; key < lo + width; key++) begin
                for (k = 0; k < loaded; k++) begin
                    if (int'(value_mem[k]) == key) begin
                        w.value  = VALUE_BITS'(key);
                        w.bucket = BKT_W'(b);
                        w.last   = 1'b0;
                        sorted_q.push_back(w);
                    end
                end
            end
            lo += width;
        end
        if (sorted_q.size() > first) begin
            w = sorted_q.pop_back();
            w.last = 1'b1;
            sorted_q.push_back(w);
        end
        loaded = 0;
    endtask

    task automatic check_word();
        sorted_word_t w;
        seen++;
        if (sorted_q.size() == 0) begin
            report("unpredicted word, value", int'(m_sorted_value), -1);
        end else begin
            w = sorted_q.pop_front();
            if (m_sorted_value !== w.value)
                report("sorted_value", int'(m_sorted_value), int'(w.value));
            if (m_bucket_index !== w.bucket)
                report("bucket_index", int'(m_bucket_index), int'(w.bucket));
            if (m_last_out !== w.last)
                report("last_out", int'(m_last_out), int'(w.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            sorted_q.delete();
            loaded      = 0;
            items_reg   = RST_N_ITEMS;
            buckets_reg = RST_N_BUCKETS;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_N_ITEMS: begin
                        items_reg = cfg_data;
                    end
                    REG_N_BUCKETS: begin
                        buckets_reg = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            // results first: a sort started at this edge cannot answer yet
            if (m_valid && m_ready) check_word();
            if (s_valid && s_ready) begin
                if (loaded < MAX_ITEMS) begin
                    value_mem[loaded] = s_value;
                    loaded++;
                end
                if (s_last_in) sort_loaded();
            end
        end
        fail_count <= errs;
        pending    <= sorted_q.size();
        checked    <= seen;
    end

endmodule

### sim/tb_bucket_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_bucket_sort_engine_unit: regression bench of the bucket sort engine
// Drives directed and random data sets under many register settings, with
// bursty input, a stalling result side and one long hold-off; a side checker
// predicts and compares every sorted word.
// ----------------------------------------------------------------------------
module tb_bucket_sort_engine_unit;
    import bse_pkg::*;

    localparam int MAX_ITEMS     = DEF_MAX_ITEMS;
    localparam int VALUE_BITS    = DEF_VALUE_BITS;
    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int HOLD_CYCLES   = 1000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_WORDS   = 50;
    localparam int OVERFLOW_LEN  = 70;

    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = REG_N_ITEMS;
    logic [KEY_W-1:0]      cfg_data       = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_value        = '0;
    logic                  s_last_in      = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [VALUE_BITS-1:0] m_sorted_value;
    logic [BKT_W-1:0]      m_bucket_index;
    logic                  m_last_out;

    int fail_count;
    int pending;
    int checked;

    // stimulus bookkeeping
    int                    words_sent   = 0;
    int                    sets_sent    = 0;
    int                    cfg_writes   = 0;
    int                    set_len_acc  = 0;
    int                    last_set_len = 0;
    int                    burst_left   = 0;
    int                    cur_keys     = 64;
    int                    phase_words  = 0;
    logic [VALUE_BITS-1:0] fixed_vals [8];

    // receiver control
    bit hold_req   = 1'b0;
    int holds_done = 0;
    int rx_mode    = 0;
    int rx_left    = 0;
    int rx_tick    = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    bucket_sort_engine_unit #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last_in      (s_last_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_bucket_index (m_bucket_index),
        .m_last_out     (m_last_out)
    );

    bse_sort_checker #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last_in      (s_last_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_bucket_index (m_bucket_index),
        .m_last_out     (m_last_out),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked)
    );

    // Clamp a raw n_items value to the key range actually used.
    function automatic int key_limit(input logic [KEY_W-1:0] ni);
        int k;
        k = int'(ni);
        if (k < 1) k = 1;
        if (k > MAX_ITEMS) k = MAX_ITEMS;
        return k;
    endfunction

    // Favor keys that are kept; leave a share of the full value range so
    // that dropped values show up in most sets.
    function automatic logic [VALUE_BITS-1:0] pick_value(input int keys);
        if ($urandom_range(0, 3) != 0) return VALUE_BITS'($urandom_range(0, keys - 1));
        return VALUE_BITS'($urandom_range(0, (1 << VALUE_BITS) - 1));
    endfunction

    // Drop valid for a gap of length n; n is at least one.
    task automatic idle(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Close the current burst, mostly with a gap, and open a new one when it runs out.
    // A long burst now and then gives stretches with no idling at all.
    task automatic pace();
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) idle($urandom_range(12, 40));
            else if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 5));
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // Offer one word and hold it until the engine takes it.
    task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic lst);
        s_valid   <= 1'b1;
        s_value   <= v;
        s_last_in <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        phase_words++;
        set_len_acc++;
        if (lst) begin
            sets_sent++;
            last_set_len = set_len_acc;
            set_len_acc  = 0;
        end
    endtask

    task automatic send_set(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            pace();
            send_word(pick_value(cur_keys), i == len - 1);
        end
    endtask

    task automatic send_fixed(input int cnt);
        int i;
        for (i = 0; i < cnt; i++) begin
            pace();
            send_word(fixed_vals[i], i == cnt - 1);
        end
    endtask

    // Write one register word, then drop valid before the next write so valid
    // never toggles twice in a step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cfg_writes++;
    endtask

    task automatic set_regs(input logic [KEY_W-1:0] ni, input logic [KEY_W-1:0] nb);
        write_reg(REG_N_ITEMS, ni);
        write_reg(REG_N_BUCKETS, nb);
        cur_keys = key_limit(ni);
    endtask

    // Drop valid, wait for every predicted word, then let the tail of the
    // last sort run out: a sort that keeps nothing gives no word to wait on.
    task automatic settle();
        int l;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        l = (last_set_len > MAX_ITEMS) ? MAX_ITEMS : last_set_len;
        repeat (2 * l * (MAX_ITEMS + 1) + 9 * (MAX_ITEMS + 1) + 64) @(posedge aclk);
    endtask

    // Pick a random setting, extremes and out-of-range values included.
    task automatic random_regs();
        logic [KEY_W-1:0] ni;
        logic [KEY_W-1:0] nb;
        case ($urandom_range(0, 5))
            0: begin
                ni = 7'd1;
            end
            1: begin
                ni = 7'd64;
            end
            2: begin
                ni = 7'd0;
            end
            3: begin
                ni = KEY_W'($urandom_range(65, 127));
            end
            default: begin
                ni = KEY_W'($urandom_range(2, 63));
            end
        endcase
        case ($urandom_range(0, 5))
            0: begin
                nb = 7'd1;
            end
            1: begin
                nb = ni;
            end
            2: begin
                nb = 7'd64;
            end
            3: begin
                nb = 7'd0;
            end
            4: begin
                nb = KEY_W'($urandom_range(65, 127));
            end
            default: begin
                nb = KEY_W'($urandom_range(1, 64));
            end
        endcase
        if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_LO, KEY_W'($urandom_range(0, 127)));
        if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_HI, KEY_W'($urandom_range(0, 127)));
        set_regs(ni, nb);
    endtask

    // Receiver: walk through stall modes of random length; on request hold
    // ready low for a long stretch so the engine backs up into its input.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(20, 300);
                end
                rx_left--;
                rx_tick++;
                case (rx_mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_ready <= ((rx_tick % 7) < 3);
                    end
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int ph;
        int r;
        int len;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: full key range, every value kept, extremes of value.
        fixed_vals = '{6'd63, 6'd0, 6'd31, 6'd32, 6'd7, 6'd7, 6'd0, 6'd0};
        send_fixed(6);
        // single-word set: the first word is also the last
        fixed_vals[0] = 6'd0;
        send_fixed(1);
        settle();

        // One bucket of one key; more words than n_items.
        set_regs(7'd1, 7'd1);
        fixed_vals = '{6'd0, 6'd5, 6'd63, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
        send_fixed(4);
        settle();

        // Bucket count above n_items saturates: five buckets of width one.
        set_regs(7'd5, 7'd64);
        fixed_vals = '{6'd4, 6'd3, 6'd2, 6'd1, 6'd0, 6'd4, 6'd0, 6'd0};
        send_fixed(6);
        settle();

        // Zero registers act as one.
        set_regs(7'd0, 7'd0);
        fixed_vals = '{6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
        send_fixed(2);
        settle();

        // n_items above the store clamps to 64; uneven widths 22, 21, 21.
        set_regs(7'd127, 7'd3);
        fixed_vals = '{6'd63, 6'd21, 6'd22, 6'd43, 6'd0, 6'd0, 6'd0, 6'd0};
        send_fixed(4);
        settle();

        // Nothing kept: every value at or above n_items.
        set_regs(7'd10, 7'd3);
        fixed_vals = '{6'd10, 6'd63, 6'd40, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
        send_fixed(3);
        settle();

        // Writes past the register list must leave (10, 3) in place.
        write_reg(REG_SPARE_LO, 7'd127);
        write_reg(REG_SPARE_HI, 7'd1);
        fixed_vals = '{6'd9, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
        send_fixed(2);
        settle();

        // Store overflow: words past the store are dropped, the sort still runs.
        set_regs(7'd64, 7'd64);
        send_set(OVERFLOW_LEN);
        settle();

        // Random phases: one setting each, then well-formed sets of random
        // size, mostly small, now and then large or exactly n_items long.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_regs();
            phase_words = 0;
            if (ph == 2) begin
                // long receiver hold-off while two sets keep coming
                hold_req = 1'b1;
                send_set(10);
                send_set(6);
            end
            while (phase_words < PHASE_WORDS) begin
                r = $urandom_range(0, 15);
                if (r == 0) len = $urandom_range(30, 64);
                else if (r == 1) len = cur_keys;
                else len = $urandom_range(1, 12);
                send_set(len);
            end
            settle();
        end

        $display("Covered %0d words in %0d data sets across %0d register writes.",
                 words_sent, sets_sent, cfg_writes);
        $display("Checked %0d sorted words; %0d long receiver hold-off(s).",
                 checked, holds_done);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #(LIMIT_CYCLES * 20);
        $display("Timeout with %0d words still predicted", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/bse_pkg.sv
hw/rtl/bse_ram.sv
hw/rtl/bse_div.sv
hw/rtl/bucket_sort_engine_unit.sv
sim/bse_sort_checker.sv
sim/tb_bucket_sort_engine_unit.sv
